[rtl/cufg_pkg.sv]
// ----------------------------------------------------------------------------
// cufg_pkg
// Shared types and constants of the capacity union-find greedy core.
// ----------------------------------------------------------------------------
package cufg_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CFG_W     = 11;
    localparam int WEIGHT_W  = 32;
    localparam int TOTAL_W   = 48;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_ORDER = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    localparam logic KIND_PAIR   = 1'b0;
    localparam logic KIND_SINGLE = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic [NODE_W-1:0]          node_a;
        logic [NODE_W-1:0]          node_b;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       last_item;
    } item_t;

    typedef struct packed {
        logic                      taken;
        status_t                   status;
        logic signed [TOTAL_W-1:0] total;
        logic                      done_res;
    } result_t;

    // One forest entry: parent pointer and the free-slot bit of a root.
    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic              slot;
    } entry_t;

endpackage

[rtl/capacity_union_find_greedy_core.sv]
// ----------------------------------------------------------------------------
// capacity_union_find_greedy_core
// Greedy accept engine over a union-find forest whose components carry one
// free-slot bit, with path compression and a saturating 48-bit total.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  -------   -----------------------------  --------------------------------
//  item      start, busy, item              beat taken when start && !busy
//  result    result_valid, result           one-cycle strobe, no back-pressure
//  config    cfg_wr_en, cfg_wr_data         written on any edge with cfg_wr_en
//
//  A flagged item (range or order) returns its result in the cycle after accept.
//  A checked item walks the forest memory one entry a cycle: for each find,
//  it walks up to the root and then walks the path again to compress it,
//  then passes the update state, and the link state when a pair joins two roots.
//  After reset and after every last_item beat, a clearing pass rewrites all
//  MAX_NODES forest entries while busy stays high.
//  The receiver cannot stall; busy alone throttles the item side.
// ----------------------------------------------------------------------------
module capacity_union_find_greedy_core
    import cufg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             result_valid,
    output result_t          result,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_COMP,
        S_UPDATE,
        S_LINK
    } state_t;

    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

    // forest memory
    entry_t            mem [MAX_NODES];
    entry_t            rd_data_reg;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    entry_t            wr_data;

    state_t                    state_reg, state_next;
    item_t                     item_reg, item_next;
    logic                      phase_b_reg, phase_b_next;
    logic [NODE_W-1:0]         cur_reg, cur_next;
    logic [NODE_W-1:0]         ra_reg, ra_next;
    logic [NODE_W-1:0]         rb_reg, rb_next;
    logic                      sa_reg, sa_next;
    logic                      sb_reg, sb_next;
    logic [NODE_W-1:0]         clr_reg, clr_next;
    logic [CFG_W-1:0]          node_count_reg, node_count_next;
    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic signed [WEIGHT_W-1:0] prev_weight_reg, prev_weight_next;
    logic                      have_prev_reg, have_prev_next;
    logic                      result_valid_reg, result_valid_next;
    result_t                   result_reg, result_next;

    logic [CFG_W-1:0]          limit;
    logic                      out_of_range;
    logic                      order_bad;
    logic [NODE_W-1:0]         root_cur;
    logic [NODE_W-1:0]         start_node;
    logic                      is_pair;
    logic                      take;
    logic                      finish;
    logic                      fin_taken;
    logic                      fin_last;
    status_t                   fin_status;
    logic signed [TOTAL_W:0]   sum;
    logic signed [TOTAL_W-1:0] sum_sat;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign limit = (node_count_reg > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : node_count_reg;
    assign out_of_range = (CFG_W'(item.node_a) >= limit)
                       || ((item.kind == KIND_PAIR) && (CFG_W'(item.node_b) >= limit));
    assign order_bad  = have_prev_reg && ($signed(item.weight) > $signed(prev_weight_reg));
    assign root_cur   = phase_b_reg ? rb_reg : ra_reg;
    assign start_node = phase_b_reg ? item_reg.node_b : item_reg.node_a;
    assign is_pair    = (item_reg.kind == KIND_PAIR);
    assign take       = is_pair ? (sa_reg | sb_reg) : sa_reg;

    assign sum = $signed({total_reg[TOTAL_W-1], total_reg})
               + $signed({{(TOTAL_W+1-WEIGHT_W){item_reg.weight[WEIGHT_W-1]}}, item_reg.weight});
    assign sum_sat = (sum[TOTAL_W] != sum[TOTAL_W-1])
                   ? (sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX)
                   : sum[TOTAL_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        phase_b_next      = phase_b_reg;
        cur_next          = cur_reg;
        ra_next           = ra_reg;
        rb_next           = rb_reg;
        sa_next           = sa_reg;
        sb_next           = sb_reg;
        clr_next          = clr_reg;
        node_count_next   = cfg_wr_en ? cfg_wr_data : node_count_reg;
        total_next        = total_reg;
        prev_weight_next  = prev_weight_reg;
        have_prev_next    = have_prev_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        rd_addr           = cur_reg;
        wr_en             = 1'b0;
        wr_addr           = cur_reg;
        wr_data           = '{parent: root_cur, slot: rd_data_reg.slot};
        finish            = 1'b0;
        fin_taken         = 1'b0;
        fin_last          = item_reg.last_item;
        fin_status        = STAT_OK;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '{parent: clr_reg, slot: 1'b1};
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NODE_W'(MAX_NODES - 1))
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (out_of_range || order_bad)
                    begin
                        finish     = 1'b1;
                        fin_last   = item.last_item;
                        fin_status = out_of_range ? STAT_RANGE : STAT_ORDER;
                    end
                    else
                    begin
                        item_next        = item;
                        prev_weight_next = item.weight;
                        have_prev_next   = 1'b1;
                        phase_b_next     = 1'b0;
                        cur_next         = item.node_a;
                        rd_addr          = item.node_a;
                        state_next       = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (rd_data_reg.parent == cur_reg)
                begin
                    if (phase_b_reg)
                    begin
                        rb_next = cur_reg;
                        sb_next = rd_data_reg.slot;
                    end
                    else
                    begin
                        ra_next = cur_reg;
                        sa_next = rd_data_reg.slot;
                    end
                    // restart from the item's node to compress the path
                    cur_next   = start_node;
                    rd_addr    = start_node;
                    state_next = S_COMP;
                end
                else
                begin
                    cur_next = rd_data_reg.parent;
                    rd_addr  = rd_data_reg.parent;
                end
            end
            S_COMP:
            begin
                if (cur_reg == root_cur)
                begin
                    if (!phase_b_reg && is_pair)
                    begin
                        phase_b_next = 1'b1;
                        cur_next     = item_reg.node_b;
                        rd_addr      = item_reg.node_b;
                        state_next   = S_WALK;
                    end
                    else
                    begin
                        state_next = S_UPDATE;
                    end
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cur_reg;
                    wr_data  = '{parent: root_cur, slot: rd_data_reg.slot};
                    cur_next = rd_data_reg.parent;
                    rd_addr  = rd_data_reg.parent;
                end
            end
            S_UPDATE:
            begin
                if (take)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ra_reg;
                    wr_data = '{parent: ra_reg,
                                slot: (is_pair && (ra_reg != rb_reg)) ? (sa_reg & sb_reg) : 1'b0};
                end
                if (take && is_pair && (ra_reg != rb_reg))
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    finish    = 1'b1;
                    fin_taken = take;
                end
            end
            S_LINK:
            begin
                // hang the root of node_b under the root of node_a
                wr_en     = 1'b1;
                wr_addr   = rb_reg;
                wr_data   = '{parent: ra_reg, slot: sb_reg};
                finish    = 1'b1;
                fin_taken = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            result_valid_next    = 1'b1;
            result_next.taken    = fin_taken;
            result_next.status   = fin_status;
            result_next.total    = fin_taken ? sum_sat : total_reg;
            result_next.done_res = fin_last;
            total_next           = fin_taken ? sum_sat : total_reg;
            state_next           = S_IDLE;
            if (fin_last)
            begin
                total_next       = '0;
                prev_weight_next = '0;
                have_prev_next   = 1'b0;
                clr_next         = '0;
                state_next       = S_CLEAR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            item_reg         <= '0;
            phase_b_reg      <= 1'b0;
            cur_reg          <= '0;
            ra_reg           <= '0;
            rb_reg           <= '0;
            sa_reg           <= 1'b0;
            sb_reg           <= 1'b0;
            clr_reg          <= '0;
            node_count_reg   <= CFG_W'(MAX_NODES);
            total_reg        <= '0;
            prev_weight_reg  <= '0;
            have_prev_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            item_reg         <= item_next;
            phase_b_reg      <= phase_b_next;
            cur_reg          <= cur_next;
            ra_reg           <= ra_next;
            rb_reg           <= rb_next;
            sa_reg           <= sa_next;
            sb_reg           <= sb_next;
            clr_reg          <= clr_next;
            node_count_reg   <= node_count_next;
            total_reg        <= total_next;
            prev_weight_reg  <= prev_weight_next;
            have_prev_reg    <= have_prev_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // an out-of-range beat answers on the next cycle with the range code
    a_range_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && out_of_range) |=> (result_valid && (result.status == STAT_RANGE)))
        else $error("range reject not answered next cycle");

    a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.taken) |-> (result.status == STAT_OK))
        else $error("taken result carries an error status");

    // compression never reads the entry it is rewriting
    a_comp_no_alias: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_COMP) && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write collide during compression");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("forest written while idle");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.done_res) |-> (busy && (state_reg == S_CLEAR) && (clr_reg == '0)))
        else $error("end of problem did not start a clearing pass");

endmodule

[bench/tb_capacity_union_find_greedy_core.sv]
// ----------------------------------------------------------------------------
// tb_capacity_union_find_greedy_core
// Self-checking bench for the greedy slot-forest core. A class keeps its own
// forest, slot bits and running total and predicts every result beat in
// order; directed items hit range, order, self-join and end-of-problem cases,
// then random problems of mostly non-rising weights run across many node counts.
// ----------------------------------------------------------------------------
module tb_capacity_union_find_greedy_core;
    import cufg_pkg::*;

    localparam longint W_MAX     = 64'sd2147483647;
    localparam longint W_MIN     = -64'sd2147483648;
    localparam longint TOTAL_HI  = 64'sd140737488355327;
    localparam longint TOTAL_LO  = -64'sd140737488355328;
    localparam int     RAND_BEATS = 1050;

    class slot_forest_board;
        int unsigned       node_count;
        logic [NODE_W-1:0] parent [MAX_NODES];
        logic              slot [MAX_NODES];
        longint            running_total;
        longint            previous_weight;
        bit                have_previous;
        result_t           pending_results[$];
        int                mismatches;

        function new();
            node_count = MAX_NODES;
            mismatches = 0;
            clear_problem();
        endfunction

        function void clear_problem();
            for (int i = 0; i < MAX_NODES; i++)
            begin
                parent[i] = NODE_W'(i);
                slot[i]   = 1'b1;
            end
            running_total   = 0;
            previous_weight = 0;
            have_previous   = 1'b0;
        endfunction

        function void set_node_count(int unsigned value);
            node_count = value & 32'h7FF;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] n);
            logic [NODE_W-1:0] r;
            logic [NODE_W-1:0] nxt;
            int                steps;
            r     = n;
            steps = 0;
            while (parent[r] != r && steps < MAX_NODES)
            begin
                r = parent[r];
                steps++;
            end
            // compress the walked path onto the root
            while (n != r)
            begin
                nxt       = parent[n];
                parent[n] = r;
                n         = nxt;
            end
            return r;
        endfunction

        function result_t greedy_outcome(item_t it);
            result_t           r;
            int unsigned       lim;
            longint            w;
            longint            s;
            logic [NODE_W-1:0] ra;
            logic [NODE_W-1:0] rb;
            bit                took;
            lim      = (node_count > MAX_NODES) ? MAX_NODES : node_count;
            w        = longint'($signed(it.weight));
            took     = 1'b0;
            r.status = STAT_OK;
            if (it.node_a >= lim || (it.kind == KIND_PAIR && it.node_b >= lim))
                r.status = STAT_RANGE;
            else if (have_previous && w > previous_weight)
                r.status = STAT_ORDER;
            else
            begin
                previous_weight = w;
                have_previous   = 1'b1;
                ra = find_root(it.node_a);
                if (it.kind == KIND_PAIR)
                begin
                    rb = find_root(it.node_b);
                    if (slot[ra] || slot[rb])
                    begin
                        if (ra != rb)
                        begin
                            slot[ra]   = slot[ra] & slot[rb];
                            parent[rb] = ra;
                        end
                        else
                            slot[ra] = 1'b0;
                        took = 1'b1;
                    end
                end
                else if (slot[ra])
                begin
                    slot[ra] = 1'b0;
                    took     = 1'b1;
                end
                if (took)
                begin
                    s = running_total + w;
                    if (s > TOTAL_HI) s = TOTAL_HI;
                    if (s < TOTAL_LO) s = TOTAL_LO;
                    running_total = s;
                end
            end
            r.taken    = took;
            r.total    = running_total[TOTAL_W-1:0];
            r.done_res = it.last_item;
            if (it.last_item)
                clear_problem();
            return r;
        endfunction

        function void note_item(item_t it);
            pending_results.push_back(greedy_outcome(it));
        endfunction

        function void flag(string field, longint want, longint got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                flag("unexpected result beat, total", 0,
                     longint'($signed(got.total)));
                return;
            end
            want = pending_results.pop_front();
            if (got.taken !== want.taken)
                flag("taken", want.taken, got.taken);
            if (got.status !== want.status)
                flag("status", want.status, got.status);
            if (got.total !== want.total)
                flag("total", longint'($signed(want.total)),
                     longint'($signed(got.total)));
            if (got.done_res !== want.done_res)
                flag("done_res", want.done_res, got.done_res);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    item_t            item;
    logic             result_valid;
    result_t          result;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    slot_forest_board model;
    int               random_sent;

    capacity_union_find_greedy_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #10 clk = ~clk;

    // score result beats before noting the item accepted at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                model.check_result(result);
            if (start && !busy)
                model.note_item(item);
        end
    end

    task automatic send_item(input item_t it);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause(input bit quiet);
        int pick;
        int g;
        if (quiet)
            return;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            g = 0;
        else if (pick < 92)
            g = $urandom_range(1, 3);
        else
            g = $urandom_range(8, 40);
        if (g != 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic issue(input logic kind, input int unsigned a, input int unsigned b,
                         input longint w, input logic last, input bit quiet);
        item_t it;
        it.kind      = kind;
        it.node_a    = NODE_W'(a);
        it.node_b    = NODE_W'(b);
        it.weight    = w[WEIGHT_W-1:0];
        it.last_item = last;
        send_item(it);
        pause(quiet);
    endtask

    // drop start, then hold until every result is back and the core is free
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (model.pending() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_node_count(input int unsigned value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model.set_node_count(value);
    endtask

    task automatic run_problem(input int unsigned cfg, input bit quiet);
        int unsigned lim;
        int          len;
        int          noise;
        int          mode;
        int unsigned a;
        int unsigned b;
        int unsigned bad;
        logic        kind;
        logic        last;
        longint      w;
        longint      wi;
        lim = (cfg > MAX_NODES) ? MAX_NODES : cfg;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(8, 40);
        mode = $urandom_range(0, 3);
        case (mode)
            0: w = longint'($signed($urandom()));
            1: w = $urandom_range(0, 1000);
            2: w = W_MAX;
            default: w = longint'($urandom_range(0, 2000)) - 1000;
        endcase
        for (int i = 0; i < len; i++)
        begin
            // leave a problem open now and then so the next one inherits state
            last  = (i == len - 1) && ($urandom_range(0, 7) != 0);
            kind  = 1'($urandom_range(0, 1));
            noise = $urandom_range(0, 9);
            if (lim == 0)
            begin
                a = $urandom_range(0, MAX_NODES - 1);
                b = $urandom_range(0, MAX_NODES - 1);
            end
            else
            begin
                a = $urandom_range(0, lim - 1);
                b = (kind == KIND_PAIR) ? $urandom_range(0, lim - 1)
                                        : $urandom_range(0, MAX_NODES - 1);
            end
            wi = w;
            if (noise == 0 && lim < MAX_NODES)
            begin
                bad = $urandom_range(lim, MAX_NODES - 1);
                if (kind == KIND_PAIR && $urandom_range(0, 1))
                    b = bad;
                else
                    a = bad;
            end
            else if (noise == 1)
            begin
                wi = w + $urandom_range(1, 1 << 20);
                if (wi > W_MAX) wi = W_MAX;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: w = w;
                    1: w = w - $urandom_range(1, 10);
                    2: w = w - $urandom_range(1, 1 << 16);
                    default: w = w - $urandom_range(1, 1 << 28);
                endcase
                if (w < W_MIN) w = W_MIN;
                wi = w;
            end
            issue(kind, a, b, wi, last, quiet);
            random_sent++;
        end
    endtask

    initial
    begin
        int unsigned cfg;
        int          sel;
        int          nprob;
        bit          quiet;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        model       = new();
        random_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // small forest: merge, tie, unused node_b, self-join, range, order
        write_node_count(4);
        issue(KIND_PAIR,   0,    1,    100,   1'b0, 1'b0);
        issue(KIND_PAIR,   1,    2,    100,   1'b0, 1'b0);
        issue(KIND_SINGLE, 2,    1023, 90,    1'b0, 1'b0);
        issue(KIND_PAIR,   0,    0,    80,    1'b0, 1'b0);
        issue(KIND_PAIR,   3,    4,    70,    1'b0, 1'b0);
        issue(KIND_SINGLE, 4,    0,    60,    1'b0, 1'b0);
        issue(KIND_SINGLE, 3,    0,    200,   1'b0, 1'b0);
        issue(KIND_PAIR,   3,    3,    -5,    1'b1, 1'b0);
        settle();

        // oversized count acts as full size; weight extremes
        write_node_count(2047);
        issue(KIND_PAIR,   1023, 0,    W_MAX, 1'b0, 1'b0);
        issue(KIND_SINGLE, 1023, 1023, W_MAX, 1'b0, 1'b0);
        issue(KIND_PAIR,   512,  511,  W_MIN, 1'b0, 1'b0);
        issue(KIND_SINGLE, 0,    0,    W_MAX, 1'b0, 1'b0);
        issue(KIND_SINGLE, 1,    1023, W_MIN, 1'b1, 1'b0);
        settle();

        // zero count: everything out of range, flagged last still clears
        write_node_count(0);
        issue(KIND_PAIR,   0,    0,    0,     1'b0, 1'b0);
        issue(KIND_SINGLE, 0,    0,    W_MIN, 1'b1, 1'b0);
        settle();

        write_node_count(1);
        issue(KIND_PAIR,   0,    0,    10,    1'b0, 1'b0);
        issue(KIND_SINGLE, 0,    0,    10,    1'b0, 1'b0);
        issue(KIND_PAIR,   0,    1,    5,     1'b0, 1'b0);
        issue(KIND_SINGLE, 0,    1023, -1,    1'b1, 1'b0);
        settle();

        write_node_count(1024);
        issue(KIND_SINGLE, 1023, 0,    -100,  1'b0, 1'b0);
        settle();

        while (random_sent < RAND_BEATS)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                cfg = 0;
            else if (sel == 1)
                cfg = 1;
            else if (sel <= 4)
                cfg = 1024;
            else if (sel == 5)
                cfg = 2047;
            else if (sel == 6)
                cfg = $urandom_range(0, 2047);
            else
                cfg = $urandom_range(2, 48);
            write_node_count(cfg);
            quiet = ($urandom_range(0, 3) == 0);
            nprob = $urandom_range(1, 4);
            repeat (nprob) run_problem(cfg, quiet);
            settle();
        end

        start <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (model.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/cufg_pkg.sv
rtl/capacity_union_find_greedy_core.sv
bench/tb_capacity_union_find_greedy_core.sv
